>>> rtl/grle_pkg.sv
// Shared types and constants for the Golomb run-length encoder.
// Command and status bundles between the controller and the datapath.
// No dependencies.
`default_nettype none

package grle_pkg;

    localparam int RUN_W     = 20;
    localparam int DIV_W     = 16;
    localparam int FIELD_W   = 16;
    localparam int UNARY_W   = 17;
    localparam int REMV_W    = 17;
    localparam int REML_W    = 5;
    localparam int KIDX_W    = 4;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef enum logic [0:0] {
        OP_ENCODE = 1'b0,
        OP_FLUSH  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        NUM_RUN,
        NUM_IDX,
        NUM_IDXM1
    } num_sel_t;

    typedef enum logic [0:0] {
        DEN_HELD,
        DEN_SYM
    } den_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DECIDE,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     latch_div;
        logic     start;
        num_sel_t num_sel;
        den_sel_t den_sel;
        logic     last;
        logic     run_clear;
        logic     run_inc;
        logic     load_out;
    } grle_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic run_mode;
        logic run_nz;
        logic idx_nz;
        logic at_limit;
        logic div_busy;
        logic out_free;
    } grle_status_t;

    // index of the highest set bit (floor of log2)
    function automatic logic [KIDX_W-1:0] msb_index(input logic [DIV_W-1:0] v);
        logic [KIDX_W-1:0] k;
        k = '0;
        for (int i = 0; i < DIV_W; i++) begin
            if (v[i]) begin
                k = KIDX_W'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/grle_ctrl.sv
// Controller state machine for the Golomb run-length encoder.
// Sequences decode, division and codeword transfers. Uses grle_pkg.
`default_nettype none

module grle_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  grle_pkg::grle_status_t     st,
    output grle_pkg::grle_cmd_t        cmd
);

    grle_pkg::state_t   state_reg, state_next;
    logic               pend2_reg, pend2_next;
    grle_pkg::num_sel_t sel2_reg, sel2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grle_pkg::ST_IDLE;
            pend2_reg <= 1'b0;
            sel2_reg  <= grle_pkg::NUM_IDX;
        end else begin
            state_reg <= state_next;
            pend2_reg <= pend2_next;
            sel2_reg  <= sel2_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pend2_next = pend2_reg;
        sel2_next  = sel2_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.num_sel = grle_pkg::NUM_IDX;
        cmd.den_sel = grle_pkg::DEN_SYM;

        unique case (state_reg)
            grle_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = grle_pkg::ST_PREP;
                end
            end
            grle_pkg::ST_PREP: begin
                cmd.latch_div = !st.is_flush && !st.run_nz && st.run_mode;
                state_next    = grle_pkg::ST_DECIDE;
            end
            grle_pkg::ST_DECIDE: begin
                if (st.is_flush) begin
                    if (st.run_nz) begin
                        cmd.start     = 1'b1;
                        cmd.num_sel   = grle_pkg::NUM_RUN;
                        cmd.den_sel   = grle_pkg::DEN_HELD;
                        cmd.last      = 1'b1;
                        cmd.run_clear = 1'b1;
                        pend2_next    = 1'b0;
                        state_next    = grle_pkg::ST_DIVIDE;
                    end else begin
                        state_next = grle_pkg::ST_IDLE;
                    end
                end else if (!(st.run_nz || st.run_mode)) begin
                    cmd.start  = 1'b1;
                    cmd.last   = 1'b1;
                    pend2_next = 1'b0;
                    state_next = grle_pkg::ST_DIVIDE;
                end else if ((st.run_nz && st.at_limit) || st.idx_nz) begin
                    cmd.start     = 1'b1;
                    cmd.num_sel   = grle_pkg::NUM_RUN;
                    cmd.den_sel   = grle_pkg::DEN_HELD;
                    cmd.run_clear = 1'b1;
                    pend2_next    = 1'b1;
                    sel2_next     = (st.run_nz && st.at_limit) ? grle_pkg::NUM_IDX
                                                               : grle_pkg::NUM_IDXM1;
                    state_next    = grle_pkg::ST_DIVIDE;
                end else begin
                    cmd.run_inc = 1'b1;
                    state_next  = grle_pkg::ST_IDLE;
                end
            end
            grle_pkg::ST_DIVIDE: begin
                if (!st.div_busy) begin
                    state_next = grle_pkg::ST_WRITE;
                end
            end
            grle_pkg::ST_WRITE: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    if (pend2_reg) begin
                        cmd.start   = 1'b1;
                        cmd.num_sel = sel2_reg;
                        cmd.last    = 1'b1;
                        pend2_next  = 1'b0;
                        state_next  = grle_pkg::ST_DIVIDE;
                    end else begin
                        state_next = grle_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = grle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/grle_div.sv
// Restoring divider, one quotient bit per cycle.
// Part of the encoder datapath. Uses grle_pkg widths.
`default_nettype none

module grle_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [grle_pkg::RUN_W-1:0]    num,
    input  wire logic [grle_pkg::DIV_W-1:0]    den,
    output logic                               busy,
    output logic [grle_pkg::RUN_W-1:0]         quo,
    output logic [grle_pkg::DIV_W-1:0]         rem
);

    localparam int NUM_W = grle_pkg::RUN_W;
    localparam int DW    = grle_pkg::DIV_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/grle_dp.sv
// Datapath: input registers, index mapping, run state, divider, codeword
// formatting and output register. Uses grle_pkg and grle_div.
`default_nettype none

module grle_dp #(
    parameter int SYMBOL_BITS      = 16,
    parameter int RUN_LIMIT_FACTOR = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [grle_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [grle_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  grle_pkg::grle_cmd_t                    cmd,
    output grle_pkg::grle_status_t                 st
);

    localparam int FW     = grle_pkg::FIELD_W;
    localparam int DW     = grle_pkg::DIV_W;
    localparam int RW     = grle_pkg::RUN_W;
    localparam int SW     = (SYMBOL_BITS < FW) ? SYMBOL_BITS : FW;
    localparam int IDX_W  = SW + 1;
    localparam int LIM_W  = DW + $clog2(RUN_LIMIT_FACTOR + 1);
    localparam int CMP_W  = (LIM_W > RW) ? LIM_W : RW;
    localparam int KW     = grle_pkg::KIDX_W;
    localparam int UW     = grle_pkg::REMV_W;

    // input registers
    logic          op_reg;
    logic [SW-1:0] samp_reg;
    logic [SW-1:0] pred_reg;
    logic          above_reg;
    logic [DW-1:0] gdiv_reg;
    logic          rmode_reg;
    logic [DW-1:0] rdiv_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= s_tuser;
            samp_reg  <= s_tdata[SW-1:0];
            pred_reg  <= s_tdata[FW+SW-1:FW];
            above_reg <= s_tdata[2*FW];
            gdiv_reg  <= s_tdata[3*FW:2*FW+1];
            rmode_reg <= s_tdata[3*FW+1];
            rdiv_reg  <= s_tdata[4*FW+1:3*FW+2];
        end
    end

    // index mapping around the prediction
    logic             s_ge_p;
    logic [SW-1:0]    abs_diff;
    logic             odd;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx_m1;

    assign s_ge_p   = samp_reg >= pred_reg;
    assign abs_diff = s_ge_p ? (samp_reg - pred_reg) : (pred_reg - samp_reg);
    assign odd      = above_reg ? !s_ge_p : (s_ge_p && (samp_reg != pred_reg));
    assign idx      = {abs_diff, 1'b0} - IDX_W'(odd);
    assign idx_m1   = idx - IDX_W'(1);

    // run state
    logic [RW-1:0]    run_reg;
    logic [DW-1:0]    held_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [DW-1:0]    held_next;

    assign held_next = (rdiv_reg == '0) ? DW'(1) : rdiv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            held_reg  <= '0;
            limit_reg <= '0;
        end else begin
            if (cmd.latch_div) begin
                held_reg  <= held_next;
                limit_reg <= LIM_W'(RUN_LIMIT_FACTOR)
                             * {{(LIM_W-DW){1'b0}}, held_next};
            end
            if (cmd.run_clear) begin
                run_reg <= '0;
            end else if (cmd.run_inc && (run_reg != grle_pkg::RUN_MAX)) begin
                run_reg <= run_reg + RW'(1);
            end
        end
    end

    // divider operands
    logic [RW-1:0] num_mux;
    logic [DW-1:0] den_mux;

    always_comb begin
        case (cmd.num_sel)
            grle_pkg::NUM_RUN:   num_mux = run_reg;
            grle_pkg::NUM_IDXM1: num_mux = {{(RW-IDX_W){1'b0}}, idx_m1};
            default:             num_mux = {{(RW-IDX_W){1'b0}}, idx};
        endcase
        if (cmd.den_sel == grle_pkg::DEN_HELD) begin
            den_mux = (held_reg == '0) ? DW'(1) : held_reg;
        end else begin
            den_mux = (gdiv_reg == '0) ? DW'(1) : gdiv_reg;
        end
    end

    logic          div_busy;
    logic [RW-1:0] div_quo;
    logic [DW-1:0] div_rem;

    grle_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .num     (num_mux),
        .den     (den_mux),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // truncated-binary parameters, fixed at divide start
    logic [KW-1:0] k_reg;
    logic [UW-1:0] u_reg;
    logic          last_reg;
    logic [KW-1:0] k_now;

    assign k_now = grle_pkg::msb_index(den_mux);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            k_reg    <= k_now;
            u_reg    <= (UW'(2) << k_now) - {1'b0, den_mux};
            last_reg <= cmd.last;
        end
    end

    logic [UW-1:0]                  r_ext;
    logic                           r_hi;
    logic [grle_pkg::REMV_W-1:0]    rv;
    logic [grle_pkg::REML_W-1:0]    rl;

    assign r_ext = {1'b0, div_rem};
    assign r_hi  = r_ext >= u_reg;
    assign rv    = r_hi ? (r_ext + u_reg) : r_ext;
    assign rl    = {1'b0, k_reg} + grle_pkg::REML_W'(r_hi);

    // output register
    logic                           mvalid_reg;
    logic [grle_pkg::M_TDATA_W-1:0] mdata_reg;
    logic                           mlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            mdata_reg <= {1'b0, rl, rv, div_quo[grle_pkg::UNARY_W-1:0]};
            mlast_reg <= last_reg;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    assign st.is_flush = (op_reg == grle_pkg::OP_FLUSH);
    assign st.run_mode = rmode_reg;
    assign st.run_nz   = (run_reg != '0);
    assign st.idx_nz   = (idx != '0);
    assign st.at_limit = CMP_W'(run_reg) >= CMP_W'(limit_reg);
    assign st.div_busy = div_busy;
    assign st.out_free = !mvalid_reg || m_tready;

endmodule

`default_nettype wire

>>> rtl/golomb_run_length_encoder.sv
// Golomb run-length encoder: one item in flight, 20-step restoring divider.
// Each input passes through PREP and DECIDE; each codeword then takes a DIVIDE and a WRITE state,
// and WRITE waits while m_tready holds back the output register. A run-extending item or an
// empty flush returns to IDLE without a codeword; an item may yield two codewords.
// Output register lets the next item in while the last codeword waits.
// aresetn (synchronous, active low) clears run count, held divisor, FSM, m_tvalid.
`default_nettype none

module golomb_run_length_encoder #(
    parameter int SYMBOL_BITS      = 16,
    parameter int RUN_LIMIT_FACTOR = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample, prediction, pred_above_mean, golomb_divisor, run_mode, run_divisor
    input  wire logic [grle_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // unary_count, remainder_value, remainder_length
    output logic [grle_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast
);

    grle_pkg::grle_cmd_t    cmd;
    grle_pkg::grle_status_t st;

    grle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    grle_dp #(
        .SYMBOL_BITS      (SYMBOL_BITS),
        .RUN_LIMIT_FACTOR (RUN_LIMIT_FACTOR)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

`default_nettype wire

>>> rtl/grle_checker.sv
// Port-level checks for golomb_run_length_encoder, bound to the top level.
// Uses grle_pkg widths.
`default_nettype none

module grle_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [grle_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tlast
);

    // a stalled transfer holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // one item at a time
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // remainder length in range, padding bit clear
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[38:34] <= 5'd17) && !m_tdata[39])
        else $error("bad remainder length");

    // remainder value fits in its length
    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[33:17] >> m_tdata[38:34]) == 17'd0))
        else $error("remainder wider than its length");

endmodule

bind golomb_run_length_encoder grle_checker u_grle_checker (.*);

`default_nettype wire

>>> verif/tb_golomb_run_length_encoder.sv
// Self-checking testbench for golomb_run_length_encoder: stream-driven stimulus,
// scoreboard class with its own codeword predictor (run mode, limit, flush).
// Depends on rtl/grle_pkg.sv and rtl/golomb_run_length_encoder.sv.
`timescale 1ns / 1ps

module tb_golomb_run_length_encoder;

    localparam int RUN_FACTOR  = 10;
    localparam int RUN_SAT     = 20'hFFFFF;
    localparam int ITEMS       = 1100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        grle_pkg::opcode_t op;
        logic [15:0]       sample;
        logic [15:0]       pred;
        logic              above;
        logic [15:0]       gdiv;
        logic              run_mode;
        logic [15:0]       rdiv;
    } symbol_req_t;

    typedef struct packed {
        logic [16:0] unary;
        logic [16:0] rem_val;
        logic [4:0]  rem_len;
        logic        last;
    } codeword_t;

    class golomb_scoreboard;
        codeword_t   codeword_q[$];
        int unsigned run_len;
        int unsigned held_div;
        int          error_count;

        function new();
            run_len = 0;
            held_div = 0;
            error_count = 0;
        endfunction

        task report_mismatch(string msg);
            if (error_count < 40) begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
            error_count++;
        endtask

        function codeword_t golomb_code(int unsigned n, int unsigned m, bit last);
            codeword_t   cw;
            int unsigned q, r, u, val, len, mm;
            if (m == 0) m = 1;
            q = n / m;
            r = n % m;
            len = 0;
            for (mm = m >> 1; mm != 0; mm >>= 1) len++;
            u = (2 << len) - m;
            if (r >= u) begin
                len++;
                val = r + u;
            end else begin
                val = r;
            end
            cw.unary   = 17'(q);
            cw.rem_val = 17'(val);
            cw.rem_len = 5'(len);
            cw.last    = last;
            return cw;
        endfunction

        function void note_input(symbol_req_t it);
            int unsigned s, p, idx, m;
            s = it.sample;
            p = it.pred;
            m = (it.gdiv == 0) ? 1 : it.gdiv;
            if (it.op == grle_pkg::OP_FLUSH) begin
                if (run_len != 0) begin
                    codeword_q.push_back(golomb_code(run_len, held_div, 1'b1));
                    run_len = 0;
                end
                return;
            end
            if (it.above) idx = (s < p) ? ((p - s) << 1) - 1 : (s - p) << 1;
            else          idx = (s > p) ? ((s - p) << 1) - 1 : (p - s) << 1;
            if (run_len != 0 || it.run_mode) begin
                if (run_len == 0) held_div = (it.rdiv == 0) ? 1 : it.rdiv;
                if (run_len >= RUN_FACTOR * held_div) begin
                    codeword_q.push_back(golomb_code(run_len, held_div, 1'b0));
                    run_len = 0;
                end else if (idx != 0) begin
                    codeword_q.push_back(golomb_code(run_len, held_div, 1'b0));
                    run_len = 0;
                    idx--;
                end else begin
                    if (run_len < RUN_SAT) run_len++;
                    return;
                end
            end
            codeword_q.push_back(golomb_code(idx, m, 1'b1));
        endfunction

        task check_result(logic [grle_pkg::M_TDATA_W-1:0] tdata, logic tlast);
            codeword_t want;
            if (codeword_q.size() == 0) begin
                report_mismatch($sformatf("unexpected codeword tdata=%h", tdata));
                return;
            end
            want = codeword_q.pop_front();
            if (tdata[16:0] !== want.unary)
                report_mismatch($sformatf("unary_count %0d, want %0d",
                                          tdata[16:0], want.unary));
            if (tdata[33:17] !== want.rem_val)
                report_mismatch($sformatf("remainder_value %0d, want %0d",
                                          tdata[33:17], want.rem_val));
            if (tdata[38:34] !== want.rem_len)
                report_mismatch($sformatf("remainder_length %0d, want %0d",
                                          tdata[38:34], want.rem_len));
            if (tlast !== want.last)
                report_mismatch($sformatf("is_last %0b, want %0b", tlast, want.last));
        endtask
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [grle_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [grle_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;

    golomb_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int cycle_count = 0;

    golomb_run_length_encoder #(
        .SYMBOL_BITS      (16),
        .RUN_LIMIT_FACTOR (RUN_FACTOR)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[golomb_run_length_encoder] ERROR");
            $finish;
        end
    end

    function automatic symbol_req_t mk(grle_pkg::opcode_t op, logic [15:0] sample,
                                       logic [15:0] pred, logic above,
                                       logic [15:0] gdiv, logic rm, logic [15:0] rdiv);
        symbol_req_t it;
        it.op       = op;
        it.sample   = sample;
        it.pred     = pred;
        it.above    = above;
        it.gdiv     = gdiv;
        it.run_mode = rm;
        it.rdiv     = rdiv;
        return it;
    endfunction

    function automatic logic [15:0] rand_div();
        return ($urandom_range(1) == 0) ? 16'($urandom_range(0, 9)) : 16'($urandom);
    endfunction

    // enters and leaves right after a rising edge
    task send_item(input symbol_req_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it.rdiv, it.run_mode, it.gdiv, it.above, it.pred, it.sample};
        s_tuser  <= it.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(it);
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.codeword_q.size() != 0) @(posedge aclk);
    endtask

    task noise_item();
        logic [15:0] p;
        p = 16'($urandom);
        send_item(mk(($urandom_range(7) == 0) ? grle_pkg::OP_FLUSH : grle_pkg::OP_ENCODE,
                     ($urandom_range(3) == 0) ? p : 16'($urandom), p,
                     1'($urandom_range(1)), rand_div(), 1'($urandom_range(1)),
                     16'($urandom)));
    endtask

    // zeros that build a run, then an optional terminator
    task run_burst();
        int unsigned rdiv, held, zeros, pick;
        logic [15:0] p;
        pick = $urandom_range(99);
        rdiv = (pick < 70) ? $urandom_range(0, 6) :
               (pick < 90) ? $urandom_range(7, 40) : $urandom_range(65535);
        held = (rdiv == 0) ? 1 : rdiv;
        zeros = (held <= 6) ? $urandom_range(0, 10 * held + 2) : $urandom_range(0, 20);
        for (int i = 0; i < zeros; i++) begin
            p = 16'($urandom);
            send_item(mk(grle_pkg::OP_ENCODE, p, p, 1'($urandom_range(1)), rand_div(),
                         (i == 0) ? 1'b1 : 1'($urandom_range(1)),
                         (i == 0) ? 16'(rdiv) : 16'($urandom)));
        end
        pick = $urandom_range(99);
        p = 16'($urandom);
        if (pick < 60) begin
            send_item(mk(grle_pkg::OP_ENCODE, p + 16'($urandom_range(1, 65535)), p,
                         1'($urandom_range(1)), rand_div(), 1'b1, 16'(rdiv)));
        end else if (pick < 80) begin
            send_item(mk(grle_pkg::OP_FLUSH, 16'($urandom), p, 1'($urandom_range(1)),
                         rand_div(), 1'($urandom_range(1)), 16'($urandom)));
        end
    endtask

    initial begin
        int goal;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain codewords at the extremes, zero divisor
        send_item(mk(grle_pkg::OP_ENCODE, 16'd0, 16'd0, 1'b0, 16'd1, 1'b0, 16'd1));
        send_item(mk(grle_pkg::OP_ENCODE, 16'hFFFF, 16'd0, 1'b0, 16'd1, 1'b0, 16'd1));
        send_item(mk(grle_pkg::OP_ENCODE, 16'd0, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0,
                     16'hFFFF));
        send_item(mk(grle_pkg::OP_ENCODE, 16'd100, 16'd200, 1'b1, 16'd0, 1'b0, 16'd0));
        send_item(mk(grle_pkg::OP_ENCODE, 16'hFFFF, 16'd0, 1'b1, 16'd3, 1'b0, 16'd5));
        // flush with nothing pending
        send_item(mk(grle_pkg::OP_FLUSH, 16'd0, 16'd0, 1'b0, 16'd1, 1'b0, 16'd1));
        // run opened by a nonzero index
        send_item(mk(grle_pkg::OP_ENCODE, 16'd7, 16'd3, 1'b0, 16'd5, 1'b1, 16'd4));
        // zero run divisor, short run, flush
        send_item(mk(grle_pkg::OP_ENCODE, 16'd9, 16'd9, 1'b0, 16'd2, 1'b1, 16'd0));
        send_item(mk(grle_pkg::OP_ENCODE, 16'd44, 16'd44, 1'b1, 16'd2, 1'b0, 16'd9));
        send_item(mk(grle_pkg::OP_FLUSH, 16'd0, 16'd0, 1'b0, 16'd2, 1'b0, 16'd7));
        // run that hits the limit, with run_mode dropping mid-run
        for (int i = 0; i < 10; i++) begin
            send_item(mk(grle_pkg::OP_ENCODE, 16'h8000, 16'h8000, i[0], 16'd6,
                         (i < 5) ? 1'b1 : 1'b0, (i == 0) ? 16'd1 : 16'hFFFF));
        end
        send_item(mk(grle_pkg::OP_ENCODE, 16'd12, 16'd10, 1'b1, 16'd6, 1'b0, 16'd1));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            goal = items_sent + ITEMS / 4;
            while (items_sent < goal) begin
                if ($urandom_range(99) < 60) run_burst();
                else noise_item();
            end
            wait_idle();
        end

        s_tvalid <= 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.error_count == 0 && sb.codeword_q.size() == 0) begin
            $display("[golomb_run_length_encoder] OK");
        end else begin
            $display("[golomb_run_length_encoder] ERROR");
        end
        $finish;
    end

endmodule
